[rtl/core/oaht_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_pkg: open addressing hash table shared types and codes
// Item layouts, command and status codes, slot word and arithmetic request.
// ----------------------------------------------------------------------------
package oaht_pkg;

    localparam int KEY_W  = 15;
    localparam int SLOT_W = 11;
    // wide enough for 503*key + 1087 and for a squared residue plus one
    localparam int VAL_W  = 24;

    localparam int HASH_MUL = 503;
    localparam int HASH_ADD = 1087;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [2:0] STS_INSERTED  = 3'd0;
    localparam logic [2:0] STS_DUPLICATE = 3'd1;
    localparam logic [2:0] STS_INS_FAIL  = 3'd2;
    localparam logic [2:0] STS_DELETED   = 3'd3;
    localparam logic [2:0] STS_DEL_MISS  = 3'd4;
    localparam logic [2:0] STS_HIT       = 3'd5;
    localparam logic [2:0] STS_MISS      = 3'd6;

    localparam logic MODE_QUAD   = 1'b0;
    localparam logic MODE_DOUBLE = 1'b1;

    // word index of the probe mode register
    localparam logic REG_PROBE_MODE = 1'b0;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot_index;
    } t_out_item;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
    } t_slot;

    localparam int SLOT_WORD_W = $bits(t_slot);

    typedef struct packed {
        logic             start;
        logic             use_table;
        logic [VAL_W-1:0] value;
    } t_mod_req;

endpackage

`default_nettype wire

[rtl/core/oaht_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2003
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/oaht_modu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_modu: shared remainder unit
// Reduces a value modulo the table size or the second modulus by reciprocal
// multiply, three pipeline steps per request.
// ----------------------------------------------------------------------------
module oaht_modu #(
    parameter int TABLE_SIZE = 2003,
    parameter int SECOND_MOD = 61,
    localparam int MAX_MOD   = (TABLE_SIZE > SECOND_MOD) ? TABLE_SIZE : SECOND_MOD,
    localparam int MODW      = $clog2(MAX_MOD + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire oaht_pkg::t_mod_req i_req,
    output logic                    o_done,
    output logic [MODW-1:0]         o_rem
);

    import oaht_pkg::*;

    // reciprocals scaled by 2^VAL_W and rounded down: the quotient estimate
    // is at most one short, so one compare and subtract ends the reduction
    localparam longint unsigned SCALE   = 64'd1 << VAL_W;
    localparam logic [VAL_W-1:0] RECIP_T = VAL_W'(SCALE / TABLE_SIZE);
    localparam logic [VAL_W-1:0] RECIP_S = VAL_W'(SCALE / SECOND_MOD);

    logic [2:0]         r_vld;
    logic               r_done;
    logic [VAL_W-1:0]   r_val;
    logic               r_use_table;
    logic [2*VAL_W-1:0] r_prod;
    logic [VAL_W-1:0]   r_qm;
    logic [MODW-1:0]    r_rem;

    logic [VAL_W-1:0]   w_recip;
    logic [MODW-1:0]    w_mod;
    logic [VAL_W-1:0]   w_modx;
    logic [2*VAL_W-1:0] w_prod;
    logic [VAL_W-1:0]   w_quot;
    logic [VAL_W-1:0]   w_qm;
    logic [VAL_W-1:0]   w_diff;
    logic [VAL_W-1:0]   w_rem;

    always_comb begin
        w_recip = r_use_table ? RECIP_T : RECIP_S;
        w_mod   = r_use_table ? MODW'(TABLE_SIZE) : MODW'(SECOND_MOD);
        w_modx  = VAL_W'(w_mod);
        w_prod  = (2*VAL_W)'(r_val) * (2*VAL_W)'(w_recip);
        w_quot  = r_prod[2*VAL_W-1:VAL_W];
        w_qm    = VAL_W'(w_quot * w_modx);
        w_diff  = r_val - r_qm;
        w_rem   = (w_diff >= w_modx) ? (w_diff - w_modx) : w_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[1:0], i_req.start};
            r_done <= r_vld[2];
            if (i_req.start) begin
                r_val       <= i_req.value;
                r_use_table <= i_req.use_table;
            end
            if (r_vld[0]) begin
                r_prod <= w_prod;
            end
            if (r_vld[1]) begin
                r_qm <= w_qm;
            end
            if (r_vld[2]) begin
                r_rem <= MODW'(w_rem);
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[rtl/core/oaht_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_ctrl: command sequencer
// Clears the table, hashes the key, scans the table and walks the probe path.
// ----------------------------------------------------------------------------
module oaht_ctrl #(
    parameter int TABLE_SIZE = 2003,
    parameter int SECOND_MOD = 61,
    parameter int MAX_PROBES = 2003,
    localparam int MAX_MOD   = (TABLE_SIZE > SECOND_MOD) ? TABLE_SIZE : SECOND_MOD,
    localparam int MODW      = $clog2(MAX_MOD + 1),
    localparam int AW        = $clog2(TABLE_SIZE)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_probe_mode,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire oaht_pkg::t_in_item              i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output oaht_pkg::t_out_item                  o_out_item,
    output oaht_pkg::t_mod_req                   o_mod_req,
    input  wire logic                            i_mod_done,
    input  wire logic [MODW-1:0]                 i_mod_rem,
    output logic                                 o_ram_we,
    output logic [AW-1:0]                        o_ram_waddr,
    output logic [oaht_pkg::SLOT_WORD_W-1:0]     o_ram_wdata,
    output logic [AW-1:0]                        o_ram_raddr,
    input  wire logic [oaht_pkg::SLOT_WORD_W-1:0] i_ram_rdata
);

    import oaht_pkg::*;

    localparam int MW = $clog2(SECOND_MOD);
    localparam int PW = $clog2(MAX_PROBES + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_PROBE,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [1:0]       r_cmd;
    logic [KEY_W-1:0] r_key;
    logic             r_mode;
    logic [1:0]       r_hstep;
    logic             r_wait;
    logic [MW-1:0]    r_h0;
    logic [MW-1:0]    r_step;
    logic [AW-1:0]    r_scan_addr;
    logic [AW-1:0]    r_slot;
    logic [AW-1:0]    r_inc;
    logic [PW-1:0]    r_pcnt;
    logic             r_issue_on;
    logic             r_chk_vld;
    logic             r_chk_last;
    logic [AW-1:0]    r_chk_slot;
    t_out_item        r_res;
    logic             r_out_vld;
    t_out_item        r_out_item;

    logic             w_is_ins;
    logic             w_is_del;
    t_slot            w_word;
    logic             w_key_hit;
    logic [AW:0]      w_sum;
    logic [AW-1:0]    w_next_slot;
    logic [AW:0]      w_inc2;
    logic [AW-1:0]    w_next_inc;
    logic [VAL_W-1:0] w_keyx;
    logic [VAL_W-1:0] w_hq;
    logic [2*MW-1:0]  w_h0x;
    logic [2*MW-1:0]  w_sq;
    logic             w_hash_last;

    always_comb begin
        w_is_ins  = (r_cmd == CMD_INSERT);
        w_is_del  = (r_cmd == CMD_DELETE);
        w_word    = t_slot'(i_ram_rdata);
        w_key_hit = w_word.used && (w_word.key == r_key);

        // next probe slot and increment, both kept below the table size
        w_sum       = {1'b0, r_slot} + {1'b0, r_inc};
        w_next_slot = (w_sum >= (AW+1)'(TABLE_SIZE)) ?
                      AW'(w_sum - (AW+1)'(TABLE_SIZE)) : AW'(w_sum);
        w_inc2      = {1'b0, r_inc} + (AW+1)'(2);
        if (r_mode == MODE_QUAD) begin
            w_next_inc = (w_inc2 >= (AW+1)'(TABLE_SIZE)) ?
                         AW'(w_inc2 - (AW+1)'(TABLE_SIZE)) : AW'(w_inc2);
        end else begin
            w_next_inc = r_inc;
        end

        w_keyx = VAL_W'(r_key);
        w_hq   = w_keyx * VAL_W'(HASH_MUL) + VAL_W'(HASH_ADD);
        w_h0x  = (2*MW)'(r_h0);
        w_sq   = w_h0x * w_h0x;

        o_mod_req.start = (r_state == S_HASH) && !r_wait;
        case (r_hstep)
            2'd0: begin
                o_mod_req.use_table = (r_mode == MODE_QUAD);
                o_mod_req.value     = (r_mode == MODE_QUAD) ? w_hq : w_keyx;
            end
            2'd1: begin
                o_mod_req.use_table = 1'b0;
                o_mod_req.value     = VAL_W'(w_sq) + VAL_W'(1);
            end
            2'd2: begin
                o_mod_req.use_table = 1'b1;
                o_mod_req.value     = VAL_W'(r_h0);
            end
            2'd3: begin
                o_mod_req.use_table = 1'b1;
                o_mod_req.value     = VAL_W'(r_step);
            end
            default: begin
                o_mod_req.use_table = 1'b1;
                o_mod_req.value     = '0;
            end
        endcase
        w_hash_last = (r_mode == MODE_QUAD) || (r_hstep == 2'd3);

        o_ram_raddr = (r_state == S_PROBE) ? r_slot : r_scan_addr;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_chk_slot;
        o_ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_scan_addr;
        end else if ((r_state == S_PROBE) && r_chk_vld) begin
            if (w_is_ins && !w_word.used) begin
                o_ram_we    = 1'b1;
                o_ram_wdata = {1'b1, r_key};
            end else if (w_is_del && w_key_hit) begin
                o_ram_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_scan_addr <= '0;
            r_wait      <= 1'b0;
            r_issue_on  <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (r_out_vld && !i_out_stall && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_scan_addr <= r_scan_addr + AW'(1);
                    if (r_scan_addr == AW'(TABLE_SIZE - 1)) begin
                        r_scan_addr <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd       <= i_in_item.command;
                        r_key       <= i_in_item.key_value;
                        r_mode      <= i_probe_mode;
                        r_hstep     <= 2'd0;
                        r_wait      <= 1'b0;
                        r_scan_addr <= '0;
                        r_issue_on  <= 1'b1;
                        r_chk_vld   <= 1'b0;
                        r_res       <= '0;
                        if ((i_in_item.command == CMD_INSERT) ||
                            (i_in_item.command == CMD_DELETE)) begin
                            r_state <= S_HASH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_HASH: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (i_mod_done) begin
                        r_wait  <= 1'b0;
                        r_hstep <= r_hstep + 2'd1;
                        case (r_hstep)
                            2'd0: begin
                                if (r_mode == MODE_QUAD) begin
                                    r_slot <= AW'(i_mod_rem);
                                    r_inc  <= AW'(1);
                                end else begin
                                    r_h0 <= MW'(i_mod_rem);
                                end
                            end
                            2'd1: r_step <= MW'(i_mod_rem);
                            2'd2: r_slot <= AW'(i_mod_rem);
                            2'd3: r_inc  <= AW'(i_mod_rem);
                            default: r_inc <= AW'(i_mod_rem);
                        endcase
                        if (w_hash_last) begin
                            r_pcnt     <= '0;
                            r_issue_on <= 1'b1;
                            r_chk_vld  <= 1'b0;
                            r_state    <= w_is_ins ? S_SCAN : S_PROBE;
                        end
                    end
                end
                S_SCAN: begin
                    // reads issue one slot a cycle, and each slot is checked in the cycle after its read
                    if (r_issue_on) begin
                        r_chk_vld   <= 1'b1;
                        r_chk_last  <= (r_scan_addr == AW'(TABLE_SIZE - 1));
                        r_scan_addr <= r_scan_addr + AW'(1);
                        if (r_scan_addr == AW'(TABLE_SIZE - 1)) begin
                            r_issue_on <= 1'b0;
                        end
                    end else begin
                        r_chk_vld <= 1'b0;
                    end
                    if (r_chk_vld) begin
                        if (w_key_hit) begin
                            r_res.status <= w_is_ins ? STS_DUPLICATE : STS_HIT;
                            r_state      <= S_DONE;
                        end else if (r_chk_last) begin
                            if (w_is_ins) begin
                                r_pcnt     <= '0;
                                r_issue_on <= 1'b1;
                                r_chk_vld  <= 1'b0;
                                r_state    <= S_PROBE;
                            end else begin
                                r_res.status <= STS_MISS;
                                r_state      <= S_DONE;
                            end
                        end
                    end
                end
                S_PROBE: begin
                    if (r_issue_on) begin
                        r_chk_vld  <= 1'b1;
                        r_chk_slot <= r_slot;
                        r_chk_last <= (r_pcnt == PW'(MAX_PROBES - 1));
                        r_pcnt     <= r_pcnt + PW'(1);
                        r_slot     <= w_next_slot;
                        r_inc      <= w_next_inc;
                        if (r_pcnt == PW'(MAX_PROBES - 1)) begin
                            r_issue_on <= 1'b0;
                        end
                    end else begin
                        r_chk_vld <= 1'b0;
                    end
                    if (r_chk_vld) begin
                        if (w_is_ins) begin
                            if (!w_word.used) begin
                                r_res.status     <= STS_INSERTED;
                                r_res.slot_index <= SLOT_W'(r_chk_slot);
                                r_state          <= S_DONE;
                            end else if (r_chk_last) begin
                                r_res.status <= STS_INS_FAIL;
                                r_state      <= S_DONE;
                            end
                        end else begin
                            if (w_key_hit) begin
                                r_res.status     <= STS_DELETED;
                                r_res.slot_index <= SLOT_W'(r_chk_slot);
                                r_state          <= S_DONE;
                            end else if (!w_word.used || r_chk_last) begin
                                r_res.status <= STS_DEL_MISS;
                                r_state      <= S_DONE;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_out_vld  <= 1'b1;
                        r_out_item <= r_res;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

[rtl/core/open_addressing_hash_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// open_addressing_hash_table: open addressing hash table of 15-bit keys
// Insert, delete and search with quadratic or additive double-hash probing.
// ----------------------------------------------------------------------------
// After reset the table runs a clearing pass, one slot a cycle, and takes no
// item until it is done; the probe mode register can be written meanwhile.
// One item is worked at a time on a single table memory, one slot read per
// cycle. Hashing uses a shared remainder unit built on a reciprocal multiply
// with a start and done handshake: one reduction in quadratic mode, four in
// double mode. A search scans the table from slot zero until the key is found
// or every slot has been read. An insert takes the hash, the same scan for a
// duplicate, then probes one slot a cycle up to MAX_PROBES probes; a delete
// takes the hash and the probe walk only. A finished result sits in an output
// register and the next item can be taken while it waits; a result still held
// there delays the posting of the next one.
module open_addressing_hash_table #(
    parameter int TABLE_SIZE = 2003,
    parameter int SECOND_MOD = 61,
    parameter int MAX_PROBES = 2003
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire oaht_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output oaht_pkg::t_out_item       o_out_item
);

    import oaht_pkg::*;

    localparam int MAX_MOD = (TABLE_SIZE > SECOND_MOD) ? TABLE_SIZE : SECOND_MOD;
    localparam int MODW    = $clog2(MAX_MOD + 1);
    localparam int AW      = $clog2(TABLE_SIZE);

    logic                   r_probe_mode;
    t_mod_req               w_mod_req;
    logic                   w_mod_done;
    logic [MODW-1:0]        w_mod_rem;
    logic                   w_ram_we;
    logic [AW-1:0]          w_ram_waddr;
    logic [SLOT_WORD_W-1:0] w_ram_wdata;
    logic [AW-1:0]          w_ram_raddr;
    logic [SLOT_WORD_W-1:0] w_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_mode <= MODE_QUAD;
        end else if (psel && penable && pwrite && (paddr[2] == REG_PROBE_MODE)) begin
            r_probe_mode <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROBE_MODE) ? {31'b0, r_probe_mode} : 32'b0;

    oaht_ctrl #(
        .TABLE_SIZE (TABLE_SIZE),
        .SECOND_MOD (SECOND_MOD),
        .MAX_PROBES (MAX_PROBES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_probe_mode (r_probe_mode),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item),
        .o_mod_req    (w_mod_req),
        .i_mod_done   (w_mod_done),
        .i_mod_rem    (w_mod_rem),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata)
    );

    oaht_modu #(
        .TABLE_SIZE (TABLE_SIZE),
        .SECOND_MOD (SECOND_MOD)
    ) u_modu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mod_req),
        .o_done  (w_mod_done),
        .o_rem   (w_mod_rem)
    );

    oaht_ram #(
        .WIDTH (SLOT_WORD_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule

`default_nettype wire
